### design/stc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial time-of-day clock package
// Operation codes, access modes and configuration register indexes shared by
// the core and its checker.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int unsigned CountWidth = 32;
    localparam int unsigned PtrWidth   = 5;
    localparam int unsigned CfgIdxWidth = 2;

    // Operation codes carried on the input channel
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_SET_MODE   = 3'd1,
        OP_READ_PULSE = 3'd2,
        OP_SET_PULSE  = 3'd3,
        OP_CLEAR_IRQ  = 3'd4,
        OP_RELOAD     = 3'd5,
        OP_STATUS     = 3'd6
    } op_t;

    // Access modes for a set-mode operation
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_SET   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_PRESET_TIME   = 2'd0,
        CFG_LOAD_ON_RESET = 2'd1
    } cfg_idx_t;

endpackage : stc_pkg
`default_nettype wire

### design/serial_time_of_day_clock_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial time-of-day clock core
// 32-bit seconds counter, read one bit at a time MSB first through a 5-bit
// pointer and set one byte at a time. One result per operation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  --------------------------------
//  s_        in         s_valid / s_ready    op, access_mode, byte_index
//  m_        out        m_valid / m_ready    data_bit, interrupt_flag,
//                                            power_lost, time_count
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One operation per cycle: the state registers and the result register are
//  loaded at the same edge as the input transfer; the result appears on m_
//  in the next cycle. s_ready stays high while the result register is empty or
//  being drained, so transfers stream with no bubbles. A stall on m_ holds
//  the result and blocks s_. Reset (synchronous, aresetn low) clears the
//  count, pointer and flags and returns preset 0, load-on-reset 1.
//
module serial_time_of_day_clock_core
    import stc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [2:0]             s_op,
    input  wire logic [1:0]             s_access_mode,
    input  wire logic [1:0]             s_byte_index,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_data_bit,
    output logic                        m_interrupt_flag,
    output logic                        m_power_lost,
    output logic [CountWidth-1:0]       m_time_count,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [CountWidth-1:0]  cfg_data
);

    // Configuration registers
    logic [CountWidth-1:0] preset_reg;
    logic                  load_reg;

    // Clock state
    logic [CountWidth-1:0] count_reg, count_next;
    logic [PtrWidth-1:0]   ptr_reg, ptr_next;
    logic                  irq_reg, irq_next;
    logic                  ploss_reg, ploss_next;

    // Result register
    logic                  m_valid_reg;
    logic                  bit_reg;
    logic                  s_xfer;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;

    // Next state for the operation on the input channel
    always_comb begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        irq_next   = irq_reg;
        ploss_next = ploss_reg;
        unique case (op_t'(s_op))
            OP_TICK: begin
                irq_next   = 1'b1;
                count_next = count_reg + CountWidth'(1);
            end
            OP_SET_MODE: begin
                if (mode_t'(s_access_mode) == MODE_READ) begin
                    ptr_next = '0;
                end else if (mode_t'(s_access_mode) == MODE_CLEAR) begin
                    count_next = '0;
                end
            end
            OP_READ_PULSE: begin
                ptr_next = ptr_reg + PtrWidth'(1);
            end
            OP_SET_PULSE: begin
                // byte increment, no carry into the next byte
                count_next[{s_byte_index, 3'b000} +: 8] =
                    count_reg[{s_byte_index, 3'b000} +: 8] + 8'd1;
                ploss_next = 1'b0;
            end
            OP_CLEAR_IRQ: begin
                irq_next = 1'b0;
            end
            OP_RELOAD: begin
                if (load_reg) begin
                    count_next = preset_reg;
                end
            end
            default: begin
                // status and unused code: no change
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preset_reg <= '0;
            load_reg   <= 1'b1;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_PRESET_TIME) begin
                preset_reg <= cfg_data;
            end else if (cfg_index == CFG_LOAD_ON_RESET) begin
                load_reg <= cfg_data[0];
            end
        end
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            irq_reg     <= 1'b0;
            ploss_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            bit_reg     <= 1'b0;
        end else begin
            if (s_xfer) begin
                count_reg   <= count_next;
                ptr_reg     <= ptr_next;
                irq_reg     <= irq_next;
                ploss_reg   <= ploss_next;
                // pointer 0 selects bit 31
                bit_reg     <= count_next[~ptr_next];
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result fields mirror the state left by the last transfer
    assign m_valid          = m_valid_reg;
    assign m_data_bit       = bit_reg;
    assign m_interrupt_flag = irq_reg;
    assign m_power_lost     = ploss_reg;
    assign m_time_count     = count_reg;

endmodule : serial_time_of_day_clock_core
`default_nettype wire

### design/stc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial time-of-day clock checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
module stc_checker
    import stc_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic [2:0]            s_op,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_interrupt_flag,
    input wire logic                  m_power_lost,
    input wire logic [CountWidth-1:0] m_time_count
);

    // A pending result holds until its transfer
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_time_count))
        else $error("result dropped or changed while stalled");

    // Empty result register never blocks the input
    a_s_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // Every input transfer yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after input transfer");

    // A tick raises the interrupt in its result
    a_tick_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_TICK) |=> m_interrupt_flag)
        else $error("tick did not raise interrupt");

    // A set pulse clears power loss in its result
    a_set_ploss: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_SET_PULSE) |=> !m_power_lost)
        else $error("set pulse left power loss flagged");

endmodule : stc_checker

bind serial_time_of_day_clock_core stc_checker u_stc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_op             (s_op),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_interrupt_flag (m_interrupt_flag),
    .m_power_lost     (m_power_lost),
    .m_time_count     (m_time_count)
);
`default_nettype wire

### bench/tb_serial_time_of_day_clock_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial time-of-day clock core testbench
// Drives operations and register writes into the core and checks every readout
// against a cycle-free model of the seconds counter, pointer and flags. A short
// directed part covers the corners; then random sequences run under three
// ready/valid idling mixes, plus one long output stall.
// ----------------------------------------------------------------------------
module tb_serial_time_of_day_clock_core;
    import stc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int STALL_CYCLES = 300;
    // Codes the core does not define: an op that must act as status, and
    // register slots that must be ignored
    localparam logic [2:0] OP_SPARE = 3'd7;
    localparam logic [CfgIdxWidth-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic                  data_bit;
        logic                  irq;
        logic                  power_lost;
        logic [CountWidth-1:0] count;
    } readout_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [2:0]             s_op = '0;
    logic [1:0]             s_access_mode = '0;
    logic [1:0]             s_byte_index = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_data_bit;
    logic                   m_interrupt_flag;
    logic                   m_power_lost;
    logic [CountWidth-1:0]  m_time_count;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [CountWidth-1:0]  cfg_data = '0;

    // Clock model state and its copy of the registers
    logic [CountWidth-1:0]  tod_count = '0;
    logic [PtrWidth-1:0]    tod_ptr = '0;
    logic                   tod_irq = 1'b0;
    logic                   tod_power_lost = 1'b0;
    logic [CountWidth-1:0]  cfg_preset = '0;
    logic                   cfg_load = 1'b1;

    readout_t expected_readouts[$];
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 33;
    int sink_idle_pct = 54;
    int sink_hold = 0;

    serial_time_of_day_clock_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_access_mode    (s_access_mode),
        .s_byte_index     (s_byte_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_bit       (m_data_bit),
        .m_interrupt_flag (m_interrupt_flag),
        .m_power_lost     (m_power_lost),
        .m_time_count     (m_time_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Apply one operation to the clock model and return the readout it gives
    function automatic readout_t clock_model_step(logic [2:0] op, logic [1:0] mode,
                                                  logic [1:0] idx);
        readout_t r;
        case (op)
            OP_TICK: begin
                tod_irq = 1'b1;
                tod_count = tod_count + CountWidth'(1);
            end
            OP_SET_MODE: begin
                if (mode == MODE_READ) begin
                    tod_ptr = '0;
                end else if (mode == MODE_CLEAR) begin
                    tod_count = '0;
                end
            end
            OP_READ_PULSE: tod_ptr = tod_ptr + PtrWidth'(1);
            OP_SET_PULSE: begin
                // byte wraps on its own, no carry upward
                tod_count[{idx, 3'b000} +: 8] = tod_count[{idx, 3'b000} +: 8] + 8'd1;
                tod_power_lost = 1'b0;
            end
            OP_CLEAR_IRQ: tod_irq = 1'b0;
            OP_RELOAD: begin
                if (cfg_load) begin
                    tod_count = cfg_preset;
                end
            end
            default: ;
        endcase
        r.data_bit = tod_count[5'd31 - tod_ptr];
        r.irq = tod_irq;
        r.power_lost = tod_power_lost;
        r.count = tod_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [CountWidth-1:0] got,
                                   logic [CountWidth-1:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Monitor: check the readout transfer first, then record the new operation
    always @(posedge aclk) begin
        readout_t want;
        if (m_valid && m_ready) begin
            if (expected_readouts.size() == 0) begin
                report_mismatch("readout with none pending", m_time_count, '0);
            end else begin
                want = expected_readouts.pop_front();
                if (m_data_bit !== want.data_bit)
                    report_mismatch("data_bit", CountWidth'(m_data_bit),
                                    CountWidth'(want.data_bit));
                if (m_interrupt_flag !== want.irq)
                    report_mismatch("interrupt_flag", CountWidth'(m_interrupt_flag),
                                    CountWidth'(want.irq));
                if (m_power_lost !== want.power_lost)
                    report_mismatch("power_lost", CountWidth'(m_power_lost),
                                    CountWidth'(want.power_lost));
                if (m_time_count !== want.count)
                    report_mismatch("time_count", m_time_count, want.count);
            end
        end
        if (s_valid && s_ready) begin
            expected_readouts.push_back(clock_model_step(s_op, s_access_mode, s_byte_index));
        end
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PRESET_TIME:   cfg_preset = cfg_data;
                CFG_LOAD_ON_RESET: cfg_load = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Readout sink: random stalls, or a long hold-off when requested
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_ready = 1'b0;
            sink_hold--;
        end else begin
            m_ready = ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Offer one operation and wait for its transfer
    task automatic send_op(logic [2:0] op, logic [1:0] mode, logic [1:0] idx);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op = op;
        s_access_mode = mode;
        s_byte_index = idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Operation whose mode and byte fields are don't-care
    task automatic send_plain(logic [2:0] op);
        send_op(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    endtask

    // Stop offering and let every pending readout arrive
    task automatic wait_for_readouts();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_readouts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CountWidth-1:0] data);
        wait_for_readouts();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Preset values biased toward byte rollovers and the extremes
    function automatic logic [CountWidth-1:0] pick_preset();
        logic [CountWidth-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: begin
                v = $urandom;
                for (int b = 0; b < 4; b++) begin
                    if ($urandom_range(0, 2) == 0) v[b*8 +: 8] = 8'hff;
                end
            end
        endcase
        return v;
    endfunction

    task automatic test_status_ops();
        send_op(OP_STATUS, 2'b11, 2'b11);
        send_op(OP_SPARE, 2'b00, 2'b00);
    endtask

    task automatic test_count_wrap();
        write_reg(CFG_PRESET_TIME, '1);
        send_plain(OP_RELOAD);
        send_plain(OP_TICK);
        send_plain(OP_CLEAR_IRQ);
    endtask

    task automatic test_set_modes();
        send_op(OP_SET_MODE, MODE_NONE, 2'b01);
        send_op(OP_SET_MODE, MODE_READ, 2'b10);
        send_plain(OP_READ_PULSE);
        send_op(OP_SET_MODE, MODE_SET, 2'b00);
        send_op(OP_SET_MODE, MODE_CLEAR, 2'b11);
    endtask

    // All bytes at 0xff: each increment must wrap its own byte only
    task automatic test_byte_increment();
        send_plain(OP_RELOAD);
        for (int b = 0; b < 4; b++) begin
            send_op(OP_SET_PULSE, 2'($urandom_range(0, 3)), 2'(b));
        end
        send_op(OP_SET_MODE, MODE_NONE, 2'b00);
    endtask

    // Reload with loading off leaves the count; spare register slots do nothing
    task automatic test_reload_disabled();
        write_reg(CFG_LOAD_ON_RESET, 32'h0);
        write_reg(CFG_PRESET_TIME, $urandom);
        send_plain(OP_RELOAD);
        send_plain(OP_TICK);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        write_reg(CFG_LOAD_ON_RESET, 32'hffff_ffff);
        send_plain(OP_RELOAD);
    endtask

    // Long hold-off on the readout side while operations keep coming
    task automatic test_output_stall();
        sink_hold = STALL_CYCLES;
        for (int i = 0; i < 20; i++) begin
            send_op(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                    2'($urandom_range(0, 3)));
        end
        wait_for_readouts();
    endtask

    // Random sequences: mostly full read-outs and set sequences, some noise
    task automatic run_random_traffic(int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_op(OP_SET_MODE, MODE_READ, 2'($urandom_range(0, 3)));
                    k = $urandom_range(30, 36);
                    for (int i = 0; i < k; i++) begin
                        send_plain(($urandom_range(0, 7) == 0) ? OP_TICK : OP_READ_PULSE);
                    end
                    sent += k + 1;
                end
                3, 4: begin
                    send_op(OP_SET_MODE, MODE_SET, 2'($urandom_range(0, 3)));
                    k = $urandom_range(1, 6);
                    for (int i = 0; i < k; i++) begin
                        send_op(OP_SET_PULSE, 2'($urandom_range(0, 3)),
                                2'($urandom_range(0, 3)));
                    end
                    send_op(OP_SET_MODE, ($urandom_range(0, 3) == 0) ? MODE_CLEAR : MODE_NONE,
                            2'($urandom_range(0, 3)));
                    sent += k + 2;
                end
                5, 6: begin
                    k = $urandom_range(1, 8);
                    for (int i = 0; i < k; i++) send_plain(OP_TICK);
                    send_plain(OP_CLEAR_IRQ);
                    sent += k + 1;
                end
                7: begin
                    send_plain(OP_RELOAD);
                    sent += 1;
                end
                default: begin
                    k = $urandom_range(1, 5);
                    for (int i = 0; i < k; i++) begin
                        send_op(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                2'($urandom_range(0, 3)));
                    end
                    sent += k;
                end
            endcase
        end
    endtask

    task automatic test_random_traffic(int src_pct, int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        for (int c = 0; c < 5; c++) begin
            write_reg(CFG_PRESET_TIME, pick_preset());
            write_reg(CFG_LOAD_ON_RESET, CountWidth'($urandom_range(0, 3) != 0));
            run_random_traffic(28);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_status_ops();
        test_count_wrap();
        test_set_modes();
        test_byte_increment();
        test_reload_disabled();
        test_output_stall();
        test_random_traffic(33, 54);
        test_random_traffic(54, 33);
        test_random_traffic(0, 0);

        wait_for_readouts();
        repeat (4) @(posedge aclk);
        if (expected_readouts.size() != 0) begin
            report_mismatch("readouts never delivered", expected_readouts.size(), '0);
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
